[hdl/olidl_pkg.sv]
// Shared types and constants for the ordered list block.
// Used by the list cells, the chunk picker and the top level.
package olidl_pkg;

   localparam int CHUNK = 16;
   localparam int CHW   = 4;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_LOCATE = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STS_OK           = 2'd0,
      STS_BAD_POSITION = 2'd1,
      STS_FULL         = 2'd2,
      STS_NOT_FOUND    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   typedef struct packed {
      logic insert;
      logic remove;
      logic find;
      logic shift;
   } cmd_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] removed_value;
      logic [9:0]  found_position;
      logic [9:0]  entry_count;
   } rsp_type;

endpackage

[hdl/olidl_cell.sv]
// One list cell: holds one entry, shifts it to or from its neighbors,
// and carries a tag and a word along the scan chain. Depends on olidl_pkg.
module olidl_cell #(
   parameter int INDEX = 0,
   parameter int PW    = 11
) (
   input  logic             clock,
   input  olidl_pkg::cmd_type cmd,
   input  logic [PW-1:0]    pos_m1,
   input  logic [PW-1:0]    cnt,
   input  logic [31:0]      value,
   input  logic [31:0]      prev_data,
   input  logic [31:0]      next_data,
   input  logic             far_tag,
   input  logic [31:0]      far_rd,
   output logic [31:0]      data,
   output logic             tag,
   output logic [31:0]      rd
);
   import olidl_pkg::*;

   localparam logic [PW-1:0] IDX = PW'(INDEX);

   logic [31:0] data_ff, data_in;
   logic        tag_ff, tag_in;
   logic [31:0] rd_ff, rd_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.insert) begin
         if (IDX == pos_m1) begin
            data_in = value;
         end else if (IDX > pos_m1) begin
            data_in = prev_data;
         end
      end else if (cmd.remove && (IDX >= pos_m1)) begin
         data_in = next_data;
      end

      tag_in = tag_ff;
      rd_in  = rd_ff;
      if (cmd.find) begin
         tag_in = (data_ff == value) && (IDX < cnt);
         rd_in  = data_ff;
      end else if (cmd.remove) begin
         tag_in = (IDX == pos_m1);
         rd_in  = data_ff;
      end else if (cmd.shift) begin
         tag_in = far_tag;
         rd_in  = far_rd;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      tag_ff  <= tag_in;
      rd_ff   <= rd_in;
   end

   assign data = data_ff;
   assign tag  = tag_ff;
   assign rd   = rd_ff;

endmodule

[hdl/olidl_pick.sv]
// Finds the first tagged cell in the lowest chunk of the scan chain and
// selects its word. Depends on olidl_pkg.
module olidl_pick (
   input  logic [olidl_pkg::CHUNK-1:0]       tags,
   input  logic [olidl_pkg::CHUNK-1:0][31:0] words,
   output logic                              hit,
   output logic [olidl_pkg::CHW-1:0]         idx,
   output logic [31:0]                       word
);
   import olidl_pkg::*;

   always_comb begin
      idx = '0;
      for (int k = CHUNK - 1; k >= 0; k--) begin
         if (tags[k]) begin
            idx = CHW'(k);
         end
      end
   end

   assign hit  = |tags;
   assign word = words[idx];

endmodule

[hdl/ordered_list_insert_delete_locate.sv]
// Top level of the ordered list: a chain of list cells, the scan control
// and the result registers. Depends on olidl_pkg, olidl_cell and olidl_pick.
//
// The req channel carries one operation per transfer: insert a word at a
// 1-based position, delete the entry at a position, or locate the first
// position holding a word. The rsp channel returns one result per request
// with the status, the removed word, the found position and the entry count.
// Insert and every rejected or unused operation complete in the accept
// cycle; the result passes through a holding register and the output
// register to rsp, and the next request may follow in the next cycle
// unless the output register is held. Delete and locate walk the cell
// chain CHUNK (16) cells per cycle: delete until it reaches the tagged
// cell at the position, locate until it finds the word or passes the
// entry count. Reset empties the list and drops any pending result. When
// the receiver stalls, one finished result waits in the output register
// and one more in a holding register; the block stops taking requests
// when both are full and while a delete or locate scans.
module ordered_list_insert_delete_locate #(
   parameter int DEPTH = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // action[1:0], position[11:2], value[43:12], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // status[1:0], removed_value[33:2],
                                    // found_position[43:34], entry_count[53:44], zero
);
   import olidl_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = ((CW > 10) ? CW : 10) + 1;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [PW-1:0]   base_ff, base_in;
   logic            del_ff, del_in;
   rsp_type         pend_ff, pend_in;
   logic            pend_valid_ff, pend_valid_in;
   rsp_type         out_ff, out_in;
   logic            rsp_valid_ff, rsp_valid_in;

   cmd_type         cmd;
   action_type      act;
   logic [PW-1:0]   pos_w, cnt_w, pos_m1, next_base, found_sum;
   logic            accept, move, out_free;

   logic [31:0]     data_w [DEPTH];
   logic            tag_w  [DEPTH];
   logic [31:0]     rd_w   [DEPTH];

   logic [CHUNK-1:0]       low_tags;
   logic [CHUNK-1:0][31:0] low_words;
   logic                   hit;
   logic [CHW-1:0]         hit_idx;
   logic [31:0]            hit_word;

   assign act    = action_type'(req_tdata[1:0]);
   assign pos_w  = PW'(req_tdata[11:2]);
   assign cnt_w  = PW'(count_ff);
   assign pos_m1 = pos_w - PW'(1);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign move       = pend_valid_ff && out_free;
   assign req_tready = (state_ff == ST_IDLE) && (!pend_valid_ff || move);
   assign accept     = req_tvalid && req_tready;

   assign next_base = base_ff + PW'(CHUNK);
   assign found_sum = base_ff + PW'(hit_idx) + PW'(1);

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [31:0] prev_d, next_d, far_d;
      logic        far_t;
      if (i == 0) begin : g_first
         assign prev_d = '0;
      end else begin : g_mid
         assign prev_d = data_w[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign next_d = '0;
      end else begin : g_body
         assign next_d = data_w[i+1];
      end
      if (i + CHUNK < DEPTH) begin : g_far
         assign far_t = tag_w[i+CHUNK];
         assign far_d = rd_w[i+CHUNK];
      end else begin : g_end
         assign far_t = 1'b0;
         assign far_d = '0;
      end
      olidl_cell #(
         .INDEX(i),
         .PW   (PW)
      ) u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .pos_m1   (pos_m1),
         .cnt      (cnt_w),
         .value    (req_tdata[43:12]),
         .prev_data(prev_d),
         .next_data(next_d),
         .far_tag  (far_t),
         .far_rd   (far_d),
         .data     (data_w[i]),
         .tag      (tag_w[i]),
         .rd       (rd_w[i])
      );
   end

   for (genvar k = 0; k < CHUNK; k++) begin : g_low
      if (k < DEPTH) begin : g_tap
         assign low_tags[k]  = tag_w[k];
         assign low_words[k] = rd_w[k];
      end else begin : g_pad
         assign low_tags[k]  = 1'b0;
         assign low_words[k] = '0;
      end
   end

   olidl_pick u_pick (
      .tags (low_tags),
      .words(low_words),
      .hit  (hit),
      .idx  (hit_idx),
      .word (hit_word)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      base_in  = base_ff;
      del_in   = del_ff;
      pend_in  = pend_ff;
      cmd      = '0;
      pend_valid_in = move ? 1'b0 : pend_valid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_in.status         = STS_OK;
               pend_in.removed_value  = '0;
               pend_in.found_position = '0;
               pend_in.entry_count    = 10'(count_ff);
               case (act)
                  ACT_INSERT: begin
                     pend_valid_in = 1'b1;
                     if ((pos_w == '0) || (pos_w > cnt_w + PW'(1))) begin
                        pend_in.status = STS_BAD_POSITION;
                     end else if (cnt_w == PW'(DEPTH)) begin
                        pend_in.status = STS_FULL;
                     end else begin
                        cmd.insert          = 1'b1;
                        count_in            = count_ff + CW'(1);
                        pend_in.entry_count = 10'(count_ff + CW'(1));
                     end
                  end
                  ACT_DELETE: begin
                     if ((pos_w == '0) || (pos_w > cnt_w)) begin
                        pend_valid_in  = 1'b1;
                        pend_in.status = STS_BAD_POSITION;
                     end else begin
                        cmd.remove = 1'b1;
                        count_in   = count_ff - CW'(1);
                        base_in    = '0;
                        del_in     = 1'b1;
                        state_in   = ST_SCAN;
                     end
                  end
                  ACT_LOCATE: begin
                     cmd.find = 1'b1;
                     base_in  = '0;
                     del_in   = 1'b0;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     pend_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cmd.shift = 1'b1;
            pend_in.status         = STS_OK;
            pend_in.removed_value  = '0;
            pend_in.found_position = '0;
            pend_in.entry_count    = 10'(count_ff);
            base_in                = next_base;
            if (hit) begin
               pend_valid_in = 1'b1;
               state_in      = ST_IDLE;
               if (del_ff) begin
                  pend_in.removed_value = hit_word;
               end else begin
                  pend_in.found_position = found_sum[9:0];
               end
            end else if (!del_ff && (next_base >= cnt_w)) begin
               pend_valid_in  = 1'b1;
               pend_in.status = STS_NOT_FOUND;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_in       = move ? pend_ff : out_ff;
      rsp_valid_in = move ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      del_ff  <= del_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, out_ff.entry_count, out_ff.found_position,
                        out_ff.removed_value, out_ff.status};

endmodule

[dv/ordered_list_insert_delete_locate_tb.sv]
// Self-checking testbench for ordered_list_insert_delete_locate: drives list operations on the
// req stream and checks every rsp transfer against a model of the list kept in the bench.
// Depends on olidl_pkg and the ordered_list_insert_delete_locate top level.
module ordered_list_insert_delete_locate_tb;
   import olidl_pkg::*;

   localparam int DEPTH        = 512;
   localparam int DRAIN_CYCLES = DEPTH / CHUNK + 8;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;

   logic [31:0] list_words [DEPTH];
   int          list_len = 0;
   rsp_type     expected_rsps [$];
   int          fail_count = 0;
   int          report_count = 0;
   bit          tx_quiet = 1'b0;
   bit          rx_quiet = 1'b0;
   int          rx_hold_cycles = 0;

   ordered_list_insert_delete_locate #(.DEPTH(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type apply_list_op(logic [1:0] act, logic [9:0] pos,
                                             logic [31:0] val);
      rsp_type r;
      int      j;
      r.status         = STS_OK;
      r.removed_value  = '0;
      r.found_position = '0;
      case (act)
         ACT_INSERT: begin
            if (pos < 1 || pos > list_len + 1) begin
               r.status = STS_BAD_POSITION;
            end else if (list_len >= DEPTH) begin
               r.status = STS_FULL;
            end else begin
               for (j = list_len; j >= pos; j--) list_words[j] = list_words[j - 1];
               list_words[pos - 1] = val;
               list_len++;
            end
         end
         ACT_DELETE: begin
            if (pos < 1 || pos > list_len) begin
               r.status = STS_BAD_POSITION;
            end else begin
               r.removed_value = list_words[pos - 1];
               for (j = pos; j < list_len; j++) list_words[j - 1] = list_words[j];
               list_len--;
            end
         end
         ACT_LOCATE: begin
            r.status = STS_NOT_FOUND;
            for (j = 0; j < list_len; j++) begin
               if (list_words[j] == val) begin
                  r.found_position = 10'(j + 1);
                  r.status         = STS_OK;
                  break;
               end
            end
         end
         default: ;
      endcase
      r.entry_count = 10'(list_len);
      return r;
   endfunction

   task automatic push_op(input logic [1:0] act, input logic [9:0] pos, input logic [31:0] val);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, val, pos, act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_rsps.push_back(apply_list_op(act, pos, val));
   endtask

   task automatic wait_for_idle;
      req_tvalid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   // Mostly legal operations on the current list, with a share of raw noise.
   task automatic push_random_op;
      logic [1:0]  act;
      logic [9:0]  pos;
      logic [31:0] val;
      int          pick;
      int          ins_share;
      case ($urandom_range(0, 7))
         0:       val = 32'h0000_0000;
         1:       val = 32'hFFFF_FFFF;
         2:       val = 32'h8000_0000;
         3:       val = 32'h7FFF_FFFF;
         4:       val = 32'h0000_0001;
         5:       val = 32'h55AA_55AA;
         6:       val = 32'hAA55_AA55;
         default: val = $urandom();
      endcase
      if ($urandom_range(0, 3) == 0) val = $urandom();
      if ($urandom_range(0, 9) < 2) begin
         act = 2'($urandom_range(0, 3));
         pos = 10'($urandom());
      end else begin
         ins_share = (list_len < 24) ? 45 : 20;
         pick      = $urandom_range(0, 99);
         if (pick < ins_share) begin
            act = ACT_INSERT;
            pos = 10'($urandom_range(1, list_len + 1));
         end else if (pick < ins_share + 30) begin
            act = ACT_DELETE;
            pos = (list_len == 0) ? 10'd1 : 10'($urandom_range(1, list_len));
         end else begin
            act = ACT_LOCATE;
            pos = 10'($urandom());
            if (list_len > 0 && $urandom_range(0, 1) == 1)
               val = list_words[$urandom_range(0, list_len - 1)];
         end
      end
      push_op(act, pos, val);
   endtask

   task automatic test_empty_list;
      push_op(ACT_LOCATE, 10'd0, 32'h0000_0000);
      push_op(ACT_DELETE, 10'd1, 32'h0000_0000);
      push_op(ACT_DELETE, 10'd0, 32'h0000_0000);
      push_op(ACT_INSERT, 10'd0, 32'h1234_5678);
      push_op(ACT_INSERT, 10'd2, 32'h1234_5678);
      push_op(ACT_NONE, 10'd1, 32'hFFFF_FFFF);
   endtask

   task automatic test_basic_edits;
      push_op(ACT_INSERT, 10'd1, 32'h8000_0000);
      push_op(ACT_INSERT, 10'd2, 32'h7FFF_FFFF);
      push_op(ACT_INSERT, 10'd1, 32'h0000_0000);
      push_op(ACT_INSERT, 10'd4, 32'hFFFF_FFFF);
      push_op(ACT_INSERT, 10'd1023, 32'h0000_0005);
      push_op(ACT_INSERT, 10'd6, 32'h0000_0005);
      push_op(ACT_INSERT, 10'd3, 32'h0000_0005);
      push_op(ACT_LOCATE, 10'd0, 32'hFFFF_FFFF);
      push_op(ACT_LOCATE, 10'd1023, 32'h0000_0000);
      push_op(ACT_LOCATE, 10'd0, 32'h0001_2345);
      push_op(ACT_INSERT, 10'd1, 32'h0000_0005);
      push_op(ACT_LOCATE, 10'd0, 32'h0000_0005);
      push_op(ACT_DELETE, 10'd1023, 32'h0000_0000);
      push_op(ACT_DELETE, 10'd7, 32'h0000_0000);
      push_op(ACT_DELETE, 10'd3, 32'h0000_0000);
      push_op(ACT_DELETE, 10'd5, 32'h0000_0000);
      push_op(ACT_DELETE, 10'd1, 32'h0000_0000);
      push_op(ACT_NONE, 10'($urandom()), $urandom());
      push_op(ACT_LOCATE, 10'd0, 32'h8000_0000);
   endtask

   task automatic test_full_list;
      tx_quiet = 1'b1;
      rx_quiet = 1'b1;
      while (list_len < DEPTH) push_op(ACT_INSERT, 10'($urandom_range(1, list_len + 1)), $urandom());
      push_op(ACT_INSERT, 10'(DEPTH + 1), $urandom());
      push_op(ACT_INSERT, 10'd1, $urandom());
      push_op(ACT_INSERT, 10'(DEPTH + 2), $urandom());
      push_op(ACT_LOCATE, 10'd0, list_words[DEPTH - 1]);
      push_op(ACT_LOCATE, 10'd0, 32'h1357_9BDF);
      push_op(ACT_DELETE, 10'(DEPTH), 32'h0000_0000);
      push_op(ACT_DELETE, 10'(DEPTH), 32'h0000_0000);
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
   endtask

   // The receiver stops for a long stretch while requests keep coming, so the
   // block fills its result registers and stalls the req side.
   task automatic test_receiver_hold;
      tx_quiet       = 1'b1;
      rx_hold_cycles = 80;
      repeat (12) push_random_op();
      tx_quiet = 1'b0;
   endtask

   task automatic test_sender_pause;
      repeat (3) begin
         repeat (5) push_random_op();
         wait_for_idle();
      end
   endtask

   task automatic test_random;
      int i;
      for (i = 0; i < 80; i++) begin
         if (i % 20 == 0) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
         end
         if (i % 40 == 39) wait_for_idle();
         push_random_op();
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status         = status_type'(rsp_tdata[1:0]);
         got.removed_value  = rsp_tdata[33:2];
         got.found_position = rsp_tdata[43:34];
         got.entry_count    = rsp_tdata[53:44];
         if (expected_rsps.size() == 0) begin
            fail_count++;
            if (report_count < 10) begin
               report_count++;
               $display("unexpected rsp transfer: %h", rsp_tdata);
            end
         end else begin
            want = expected_rsps.pop_front();
            if (got.status !== want.status || got.removed_value !== want.removed_value ||
                got.found_position !== want.found_position ||
                got.entry_count !== want.entry_count) begin
               fail_count++;
               if (report_count < 10) begin
                  report_count++;
                  $display("rsp mismatch: status %0d/%0d removed %h/%h found %0d/%0d count %0d/%0d",
                           want.status, got.status, want.removed_value, got.removed_value,
                           want.found_position, got.found_position,
                           want.entry_count, got.entry_count);
               end
            end
         end
      end
   end

   initial begin
      int stall;
      rsp_tready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         stall          = rx_quiet ? 0 : $urandom_range(0, 6);
         stall          = stall + rx_hold_cycles;
         rx_hold_cycles = 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_basic_edits();
      test_receiver_hold();
      test_sender_pause();
      test_random();
      test_full_list();
      wait_for_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("FAILURE");
      $finish;
   end

endmodule
